// ===== rtl/core/orec_pkg.sv =====
// ----------------------------------------------------------------------------
// orec_pkg
// Shared types and fixed field widths of the optimal-replacement eviction
// counter.
// ----------------------------------------------------------------------------
package orec_pkg;

   localparam int ID_W       = 8;   // request identifier
   localparam int COUNT_W    = 8;   // eviction count
   localparam int CFG_W      = 5;   // slot count register
   localparam int SLOT_NUM_W = 7;   // effective slot count, up to 31

   localparam logic [CFG_W-1:0]   SLOT_COUNT_RESET = CFG_W'(1);
   localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;

   typedef logic [ID_W-1:0] id_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ===== rtl/core/orec_front.sv =====
// ----------------------------------------------------------------------------
// orec_front
// Takes requests, writes them into the request memory in order and hands a
// job with the sequence length to the job queue on the last request.
// ----------------------------------------------------------------------------
module orec_front #(
   parameter int MAX_REQUESTS = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  orec_pkg::id_type                    request_id,
   input  logic                                last_request,
   output logic                                mem_we,
   output logic [$clog2(MAX_REQUESTS)-1:0]     mem_waddr,
   output orec_pkg::id_type                    mem_wdata,
   output logic                                job_push,
   output logic [$clog2(MAX_REQUESTS+1)-1:0]   job_total
);
   import orec_pkg::*;

   localparam int AW = $clog2(MAX_REQUESTS);
   localparam int CW = $clog2(MAX_REQUESTS + 1);

   logic [CW-1:0] wr_cnt_ff, wr_cnt_in;
   logic          has_room;

   // requests past the end of the memory are dropped
   assign has_room  = wr_cnt_ff < CW'(MAX_REQUESTS);
   assign mem_we    = accept && has_room;
   assign mem_waddr = wr_cnt_ff[AW-1:0];
   assign mem_wdata = request_id;
   assign job_push  = accept && last_request;
   assign job_total = has_room ? CW'(wr_cnt_ff + 1'b1) : wr_cnt_ff;

   always_comb begin
      wr_cnt_in = wr_cnt_ff;
      if (job_push) begin
         wr_cnt_in = '0;
      end else if (mem_we) begin
         wr_cnt_in = CW'(wr_cnt_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_cnt_ff <= '0;
      end else begin
         wr_cnt_ff <= wr_cnt_in;
      end
   end

endmodule

// ===== rtl/core/orec_job_queue.sv =====
// ----------------------------------------------------------------------------
// orec_job_queue
// Two-entry queue of pending jobs between the front and the replay engine.
// ----------------------------------------------------------------------------
module orec_job_queue #(
   parameter int W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [W-1:0]                push_data,
   input  logic                        pop,
   output logic [W-1:0]                pop_data,
   output orec_pkg::queue_status_type  status
);
   import orec_pkg::*;

   logic [W-1:0] data_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;
   logic         do_push, do_pop;

   assign status.empty = count_ff == 2'd0;
   assign status.full  = count_ff == 2'd2;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = data_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         priority case ({do_push, do_pop})
            2'b10:   count_ff <= 2'(count_ff + 2'd1);
            2'b01:   count_ff <= 2'(count_ff - 2'd1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== rtl/core/orec_replay.sv =====
// ----------------------------------------------------------------------------
// orec_replay
// Replay engine: holds the request memory and the slot holders, walks the
// stored sequence and applies optimal replacement through a single memory read port.
// ----------------------------------------------------------------------------
module orec_replay #(
   parameter int MAX_REQUESTS = 128,
   parameter int MAX_SLOTS    = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                mem_we,
   input  logic [$clog2(MAX_REQUESTS)-1:0]     mem_waddr,
   input  orec_pkg::id_type                    mem_wdata,
   input  logic [MAX_SLOTS-1:0]                active,
   input  orec_pkg::queue_status_type          q_status,
   input  logic [$clog2(MAX_REQUESTS+1)-1:0]   job_total,
   output logic                                job_pop,
   output logic                                engine_busy,
   output logic                                rsp_valid,
   output logic [orec_pkg::COUNT_W-1:0]        rsp_count
);
   import orec_pkg::*;

   localparam int AW = $clog2(MAX_REQUESTS);
   localparam int CW = $clog2(MAX_REQUESTS + 1);
   localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_FETCH, S_CHECK, S_SCAN, S_EVICT, S_DONE
   } state_type;

   id_type               mem [MAX_REQUESTS];
   id_type               rd_data_ff;
   logic [AW-1:0]        rd_addr;

   state_type            state_ff;
   id_type               holder_ff [MAX_SLOTS];
   logic [MAX_SLOTS-1:0] found_ff;
   logic [SW-1:0]        last_ff;
   id_type               cur_ff;
   logic [CW-1:0]        total_ff, i_ff, k_ff;
   logic                 pend_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic                 rsp_valid_ff;

   logic [MAX_SLOTS-1:0] hit_vec, empty_vec, match_vec, unfound_vec;
   logic [SW-1:0]        empty_idx, match_idx, unfound_idx, victim_idx;
   logic                 issue, all_found, last_item;

   always_comb begin
      for (int j = 0; j < MAX_SLOTS; j++) begin
         hit_vec[j]     = active[j] && holder_ff[j] == rd_data_ff;
         empty_vec[j]   = active[j] && holder_ff[j] == '0;
         match_vec[j]   = active[j] && !found_ff[j] && holder_ff[j] == rd_data_ff;
         unfound_vec[j] = active[j] && !found_ff[j];
      end
   end

   // lowest index wins
   always_comb begin
      empty_idx   = '0;
      match_idx   = '0;
      unfound_idx = '0;
      for (int j = MAX_SLOTS - 1; j >= 0; j--) begin
         if (empty_vec[j]) begin
            empty_idx = SW'(j);
         end
         if (match_vec[j]) begin
            match_idx = SW'(j);
         end
         if (unfound_vec[j]) begin
            unfound_idx = SW'(j);
         end
      end
   end

   // holders are distinct at eviction time, so the slot found last is the farthest
   assign all_found  = ~|unfound_vec;
   assign victim_idx = all_found ? last_ff : unfound_idx;
   assign issue      = (state_ff == S_SCAN) && (k_ff < total_ff) && !all_found;
   assign last_item  = CW'(i_ff + 1'b1) == total_ff;

   always_comb begin
      unique case (state_ff)
         S_FETCH: rd_addr = i_ff[AW-1:0];
         S_SCAN:  rd_addr = k_ff[AW-1:0];
         default: rd_addr = '0;
      endcase
   end

   assign job_pop     = (state_ff == S_IDLE) && !q_status.empty;
   assign engine_busy = state_ff != S_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_count   = count_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         found_ff     <= '0;
         count_ff     <= '0;
         for (int j = 0; j < MAX_SLOTS; j++) begin
            holder_ff[j] <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (job_pop) begin
                  total_ff <= job_total;
                  i_ff     <= '0;
                  count_ff <= '0;
                  for (int j = 0; j < MAX_SLOTS; j++) begin
                     holder_ff[j] <= '0;
                  end
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (|hit_vec || |empty_vec) begin
                  if (!(|hit_vec)) begin
                     holder_ff[empty_idx] <= rd_data_ff;
                  end
                  if (last_item) begin
                     state_ff <= S_DONE;
                  end else begin
                     i_ff     <= CW'(i_ff + 1'b1);
                     state_ff <= S_FETCH;
                  end
               end else begin
                  cur_ff   <= rd_data_ff;
                  found_ff <= '0;
                  pend_ff  <= 1'b0;
                  k_ff     <= CW'(i_ff + 1'b1);
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               // reads issue one per cycle, and the registered read data is checked in the cycle after its read
               pend_ff <= issue;
               if (issue) begin
                  k_ff <= CW'(k_ff + 1'b1);
               end
               if (pend_ff && |match_vec) begin
                  found_ff[match_idx] <= 1'b1;
                  last_ff             <= match_idx;
               end
               if (!issue && !pend_ff) begin
                  state_ff <= S_EVICT;
               end
            end
            S_EVICT: begin
               holder_ff[victim_idx] <= cur_ff;
               if (count_ff != COUNT_MAX) begin
                  count_ff <= COUNT_W'(count_ff + 1'b1);
               end
               if (last_item) begin
                  state_ff <= S_DONE;
               end else begin
                  i_ff     <= CW'(i_ff + 1'b1);
                  state_ff <= S_FETCH;
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/optimal_replacement_eviction_count.sv =====
// ----------------------------------------------------------------------------
// optimal_replacement_eviction_count
// Counts evictions of a request sequence under optimal (farthest next use)
// replacement over a configurable number of slots.
// ----------------------------------------------------------------------------
// loading: one request per cycle while busy is low; the last request queues a job that starts the replay
// replay: a hit or fill is a fetch and a check, an eviction adds a scan of the later requests
//   and an evict step; scan reads run until one past the point all holders are seen
// the result strobe is registered from the done state after replay; busy drops with the strobe
// reset clears the counters, the job queue and sets the slot count to one;
//   the request memory is not cleared, the result cannot be stalled
module optimal_replacement_eviction_count #(
   parameter int MAX_REQUESTS = 128,
   parameter int MAX_SLOTS    = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  orec_pkg::id_type              req_request_id,
   input  logic                          req_last_request,
   output logic                          rsp_valid,
   output logic [orec_pkg::COUNT_W-1:0]  rsp_eviction_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [orec_pkg::CFG_W-1:0]    csr_slot_count
);
   import orec_pkg::*;

   localparam int AW = $clog2(MAX_REQUESTS);
   localparam int CW = $clog2(MAX_REQUESTS + 1);

   logic [CFG_W-1:0]      slot_count_ff;
   logic [SLOT_NUM_W-1:0] slot_num_raw, slot_num;
   logic [MAX_SLOTS-1:0]  active;

   logic                  accept;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   id_type                mem_wdata;
   logic                  job_push, job_pop;
   logic [CW-1:0]         job_total, job_head;
   queue_status_type      q_status;
   logic                  engine_busy;

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign busy      = !q_status.empty || engine_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SLOT_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         slot_count_ff <= csr_slot_count;
      end
   end

   // zero acts as one slot, larger values clip to the slot array
   assign slot_num_raw = SLOT_NUM_W'(slot_count_ff);
   always_comb begin
      priority if (slot_num_raw == '0) begin
         slot_num = SLOT_NUM_W'(1);
      end else if (slot_num_raw > SLOT_NUM_W'(MAX_SLOTS)) begin
         slot_num = SLOT_NUM_W'(MAX_SLOTS);
      end else begin
         slot_num = slot_num_raw;
      end
      for (int j = 0; j < MAX_SLOTS; j++) begin
         active[j] = SLOT_NUM_W'(j) < slot_num;
      end
   end

   orec_front #(
      .MAX_REQUESTS (MAX_REQUESTS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .request_id   (req_request_id),
      .last_request (req_last_request),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .job_push     (job_push),
      .job_total    (job_total)
   );

   orec_job_queue #(
      .W (CW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_total),
      .pop       (job_pop),
      .pop_data  (job_head),
      .status    (q_status)
   );

   orec_replay #(
      .MAX_REQUESTS (MAX_REQUESTS),
      .MAX_SLOTS    (MAX_SLOTS)
   ) u_replay (
      .clock       (clock),
      .reset       (reset),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .active      (active),
      .q_status    (q_status),
      .job_total   (job_head),
      .job_pop     (job_pop),
      .engine_busy (engine_busy),
      .rsp_valid   (rsp_valid),
      .rsp_count   (rsp_eviction_count)
   );

   // a final request keeps the block busy until its result is out
   a_last_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_request) |=> busy)
      else $error("busy not raised after final request");

   // a result only ends a replay
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(engine_busy))
      else $error("result strobe without replay");

   // one strobe per sequence
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe repeated");

   // the queue never fills since loading stalls on a pending job
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !q_status.full)
      else $error("job queue overflow");

endmodule
